FILE: rtl/qpyb_pkg.sv
package qpyb_pkg;

  // Bin count and field widths
  localparam int BINS  = 18;
  localparam int BIN_W = 5;

  // Angles in radians, 16 fractional bits
  localparam int ANG_W       = 20;
  localparam int ANG_PI      = 205887;
  localparam int ANG_HALF_PI = 102944;

  // Datapath widths
  localparam int PROD_W = 32;
  localparam int SIN_W  = 32;
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 35;
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  localparam int CW     = 40;

  // Iteration counts
  localparam int SQRT_ITERS   = 31;
  localparam int SQRT_TOP     = 2 * (SQRT_ITERS - 1);
  localparam int CORDIC_ITERS = 16;

  // Binning arithmetic
  localparam int U_W    = 20;
  localparam int V_W    = U_W + $clog2(BINS + 1);
  localparam int Q_W    = $clog2(BINS + 1) + 1;
  localparam int DIV_SH = 32;
  localparam int RCP_W  = 16;

  // Lanes of the angle datapath
  localparam int LANES      = 2;
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;

  localparam longint PITCH_SPAN = 2 * ANG_HALF_PI;
  localparam longint YAW_SPAN   = 2 * ANG_PI;

  localparam logic signed [ANG_W-1:0] HALF_TAB [LANES] = '{
    ANG_W'(ANG_HALF_PI), ANG_W'(ANG_PI)
  };
  localparam logic [U_W-1:0] SPAN_TAB [LANES] = '{
    U_W'(PITCH_SPAN), U_W'(YAW_SPAN)
  };
  localparam logic [RCP_W-1:0] RCP_TAB [LANES] = '{
    RCP_W'((64'd1 << DIV_SH) / PITCH_SPAN), RCP_W'((64'd1 << DIV_SH) / YAW_SPAN)
  };

  // atan(2^-i) in radians, 16 fractional bits
  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
    20'sd16, 20'sd8, 20'sd4, 20'sd2
  };

  // Pipeline stage map
  localparam int ST_PROD = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_RAD  = 3;
  localparam int ST_PREP = ST_RAD + SQRT_ITERS + 1;
  localparam int ST_ANG  = ST_PREP + CORDIC_ITERS + 1;
  localparam int ST_SCL  = ST_ANG + 1;
  localparam int ST_QUO  = ST_SCL + 1;
  localparam int ST_BIN  = ST_QUO + 1;
  localparam int NST     = ST_BIN + 1;

endpackage

FILE: rtl/quaternion_to_pitch_yaw_bins.sv
// Quaternion to pitch/yaw bins.
// Input channel: quat_w/x/y/z (signed Q1.15) with quat_valid/quat_ready.
// Output channel: pitch_bin, yaw_bin with bin_valid/bin_ready; one result
// transaction for every input transaction, in order.
// Pitch = asin(clamped 2(wy-zx)) over [-pi/2, pi/2], yaw = atan2 of the
// quaternion's heading terms over [-pi, pi], each cut into 0..BINS.
// The stages are: products, sine clamp, square, radicand, a 31-stage
// integer square root, CORDIC setup, a 16-stage CORDIC running pitch and
// yaw side by side, and four binning stages. Throughput is one transaction
// per cycle while the receiver keeps bin_ready high.
// Every stage carries its own valid bit and advances when its successor is
// empty or moving, so bubbles collapse and input keeps flowing while a
// result waits at the output. When the receiver stalls, results pile up in
// the stages back to the input, then quat_ready drops; nothing is lost or
// repeated. Reset (synchronous, active high) empties the pipeline.
module quaternion_to_pitch_yaw_bins (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [15:0]              quat_w,
  input  logic signed [15:0]              quat_x,
  input  logic signed [15:0]              quat_y,
  input  logic signed [15:0]              quat_z,
  input  logic                            quat_valid,
  output logic                            quat_ready,
  output logic [qpyb_pkg::BIN_W-1:0]      pitch_bin,
  output logic [qpyb_pkg::BIN_W-1:0]      yaw_bin,
  output logic                            bin_valid,
  input  logic                            bin_ready
);
  import qpyb_pkg::*;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  // Stage advance: a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NST-1] = !vld[NST-1] || bin_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= quat_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign quat_ready = rdy[0];
  assign bin_valid  = vld[NST-1];

  // Products, Q2.30
  logic signed [PROD_W-1:0] p_wy, p_zx, p_wz, p_xy, p_yy, p_zz;
  always_ff @(posedge clk) begin
    if (rdy[ST_PROD]) begin
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // Pitch sine with clamp, yaw numerator and denominator
  localparam logic signed [NUM_W-1:0] Q30_P = NUM_W'(64'sd1 << 30);
  localparam logic signed [NUM_W-1:0] Q30_N = -Q30_P;
  logic signed [32:0]      dif, hsum;
  logic [32:0]             sqsum;
  logic signed [NUM_W-1:0] sin_raw;
  logic signed [SIN_W-1:0] sin_c;
  always_comb begin
    dif     = 33'(p_wy) - 33'(p_zx);
    hsum    = 33'(p_wz) + 33'(p_xy);
    sqsum   = 33'(unsigned'(p_yy)) + 33'(unsigned'(p_zz));
    sin_raw = signed'({dif, 1'b0});
    if (sin_raw > Q30_P) sin_c = SIN_W'(Q30_P);
    else if (sin_raw < Q30_N) sin_c = SIN_W'(Q30_N);
    else sin_c = SIN_W'(sin_raw);
  end

  logic signed [SIN_W-1:0] s1;
  logic signed [NUM_W-1:0] num1;
  logic signed [DEN_W-1:0] den1;
  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      s1   <= sin_c;
      num1 <= signed'({hsum, 1'b0});
      den1 <= DEN_W'(Q30_P) - signed'({1'b0, sqsum, 1'b0});
    end
  end

  // Square of the sine
  logic [ROOT_W-1:0] s_mag;
  assign s_mag = s1[SIN_W-1] ? ROOT_W'(-s1) : s1[ROOT_W-1:0];

  logic [RAD_W-1:0]        ssq2;
  logic signed [SIN_W-1:0] s2;
  logic signed [NUM_W-1:0] num2;
  logic signed [DEN_W-1:0] den2;
  always_ff @(posedge clk) begin
    if (rdy[ST_SQ]) begin
      ssq2 <= s_mag * s_mag;
      s2   <= s1;
      num2 <= num1;
      den2 <= den1;
    end
  end

  // Integer square root of 2^60 - s^2, one result bit per stage
  logic [RAD_W-1:0]        q_n   [SQRT_ITERS+1];
  logic [RAD_W-1:0]        q_r   [SQRT_ITERS+1];
  logic signed [SIN_W-1:0] q_s   [SQRT_ITERS+1];
  logic signed [NUM_W-1:0] q_num [SQRT_ITERS+1];
  logic signed [DEN_W-1:0] q_den [SQRT_ITERS+1];

  always_ff @(posedge clk) begin
    if (rdy[ST_RAD]) begin
      q_n[0]   <= (RAD_W'(1) << SQRT_TOP) - ssq2;
      q_r[0]   <= '0;
      q_s[0]   <= s2;
      q_num[0] <= num2;
      q_den[0] <= den2;
    end
  end

  for (genvar k = 1; k <= SQRT_ITERS; k++) begin : g_sqrt
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (SQRT_TOP - 2 * (k - 1));
    logic [RAD_W-1:0] trial;
    assign trial = q_r[k-1] + BIT;
    always_ff @(posedge clk) begin
      if (rdy[ST_RAD+k]) begin
        if (q_n[k-1] >= trial) begin
          q_n[k] <= q_n[k-1] - trial;
          q_r[k] <= (q_r[k-1] >> 1) + BIT;
        end else begin
          q_n[k] <= q_n[k-1];
          q_r[k] <= q_r[k-1] >> 1;
        end
        q_s[k]   <= q_s[k-1];
        q_num[k] <= q_num[k-1];
        q_den[k] <= q_den[k-1];
      end
    end
  end

  // CORDIC vectoring, pitch and yaw lanes
  logic signed [CW-1:0]    cx  [CORDIC_ITERS+1][LANES];
  logic signed [CW-1:0]    cy  [CORDIC_ITERS+1][LANES];
  logic signed [ANG_W-1:0] cz  [CORDIC_ITERS+1][LANES];
  logic                    cfx [CORDIC_ITERS+1][LANES];

  logic signed [CW-1:0] in_x [LANES];
  logic signed [CW-1:0] in_y [LANES];
  assign in_y[LANE_PITCH] = CW'(q_s[SQRT_ITERS]);
  assign in_x[LANE_PITCH] = CW'(signed'({1'b0, q_r[SQRT_ITERS][ROOT_W-1:0]}));
  assign in_y[LANE_YAW]   = CW'(q_num[SQRT_ITERS]);
  assign in_x[LANE_YAW]   = CW'(q_den[SQRT_ITERS]);

  localparam logic signed [ANG_W-1:0] A_PI   = ANG_W'(ANG_PI);
  localparam logic signed [ANG_W-1:0] A_HALF = ANG_W'(ANG_HALF_PI);

  for (genvar l = 0; l < LANES; l++) begin : g_prep
    logic signed [CW-1:0]    px, py;
    logic signed [ANG_W-1:0] pz;
    logic                    pf;
    // Axis cases give a fixed angle; left half plane is turned by pi
    always_comb begin
      px = in_x[l];
      py = in_y[l];
      pz = '0;
      pf = 1'b0;
      if (in_x[l] == 0) begin
        pf = 1'b1;
        if (in_y[l] > 0) pz = A_HALF;
        else if (in_y[l] < 0) pz = -A_HALF;
      end else if (in_y[l] == 0) begin
        pf = 1'b1;
        if (in_x[l] < 0) pz = A_PI;
      end else if (in_x[l] < 0) begin
        pz = (in_y[l] > 0) ? A_PI : -A_PI;
        px = -in_x[l];
        py = -in_y[l];
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[ST_PREP]) begin
        cx[0][l]  <= px;
        cy[0][l]  <= py;
        cz[0][l]  <= pz;
        cfx[0][l] <= pf;
      end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic signed [CW-1:0] xs, ys;
      assign xs = cx[i][l] >>> i;
      assign ys = cy[i][l] >>> i;
      always_ff @(posedge clk) begin
        if (rdy[ST_PREP+1+i]) begin
          if (cy[i][l] > 0) begin
            cx[i+1][l] <= cx[i][l] + ys;
            cy[i+1][l] <= cy[i][l] - xs;
            cz[i+1][l] <= cfx[i][l] ? cz[i][l] : cz[i][l] + ATAN_TAB[i];
          end else begin
            cx[i+1][l] <= cx[i][l] - ys;
            cy[i+1][l] <= cy[i][l] + xs;
            cz[i+1][l] <= cfx[i][l] ? cz[i][l] : cz[i][l] - ATAN_TAB[i];
          end
          cfx[i+1][l] <= cfx[i][l];
        end
      end
    end
  end

  // Binning: clamp, offset, scale, divide by span via reciprocal
  logic [U_W-1:0] u_a [LANES];
  logic [V_W-1:0] v_s [LANES];
  logic [V_W-1:0] v_q [LANES];
  logic [Q_W-1:0] q_q [LANES];
  logic [BIN_W-1:0] bin_n [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_bin
    logic signed [ANG_W-1:0] ac;
    logic [V_W+RCP_W-1:0]    prod;
    logic [V_W-1:0]          rem;
    logic [Q_W-1:0]          qf;
    always_comb begin
      ac = cz[CORDIC_ITERS][l];
      if (ac > HALF_TAB[l]) ac = HALF_TAB[l];
      else if (ac < -HALF_TAB[l]) ac = -HALF_TAB[l];
    end
    assign prod = v_s[l] * RCP_TAB[l];
    assign rem  = v_q[l] - V_W'(q_q[l]) * V_W'(SPAN_TAB[l]);
    assign qf   = q_q[l] + Q_W'(rem >= V_W'(SPAN_TAB[l]));
    assign bin_n[l] = qf[BIN_W-1:0];

    always_ff @(posedge clk) begin
      if (rdy[ST_ANG]) u_a[l] <= U_W'(ac + HALF_TAB[l]);
      if (rdy[ST_SCL]) v_s[l] <= V_W'(u_a[l] * BINS);
      if (rdy[ST_QUO]) begin
        q_q[l] <= prod[DIV_SH +: Q_W];
        v_q[l] <= v_s[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_BIN]) begin
      pitch_bin <= bin_n[LANE_PITCH];
      yaw_bin   <= bin_n[LANE_YAW];
    end
  end

endmodule
